FILE: hdl/lpfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants of the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

    // Frame markers
    localparam logic [7:0]  START_BYTE       = 8'h01;
    localparam logic [7:0]  END_BYTE         = 8'h04;
    localparam logic [2:0]  LEN_PREFIX_BYTES = 3'd4;
    localparam logic [31:0] INFO_PACKET_LEN  = 32'd13;
    localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;

    // Configuration registers
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE    = 1'b1;
    localparam logic [15:0] MAX_PAYLOAD_LEN_RESET = 16'd512;
    localparam logic [15:0] COMMAND_CODE_RESET    = 16'h0122;

    // Parser phase
    typedef enum logic [1:0] {
        PH_WAIT_START = 2'd0,
        PH_WAIT_LEN   = 2'd1,
        PH_WAIT_DATA  = 2'd2,
        PH_WAIT_EOT   = 2'd3
    } t_phase;

    // Status from the control unit
    typedef struct packed {
        logic        data_byte;   // next item is a payload byte
        logic        eot_byte;    // next item is the end byte
        logic [31:0] count;       // payload bytes received so far
    } t_ctrl_stat;

    // Fields decoded from the header store
    typedef struct packed {
        logic [15:0] command;
        logic        update_enable;
        logic [15:0] firmware_version;
        logic [31:0] image_total_size;
        logic [31:0] package_count;
    } t_hdr_fields;

endpackage

FILE: hdl/lpfp_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_byte_if
// Valid/ready channel carrying one stream byte per item.
// ----------------------------------------------------------------------------
interface lpfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

FILE: hdl/lpfp_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_result_if
// Valid/ready channel carrying one frame result per item.
// ----------------------------------------------------------------------------
interface lpfp_result_if;
    logic        valid;
    logic        ready;
    logic        eot_missing;
    logic        packet_accepted;
    logic        update_enable;
    logic [15:0] firmware_version;
    logic [31:0] image_total_size;
    logic [31:0] package_count;
    logic [31:0] payload_length;

    modport source (
        output valid, output eot_missing, output packet_accepted, output update_enable,
        output firmware_version, output image_total_size, output package_count,
        output payload_length, input ready
    );
    modport sink (
        input valid, input eot_missing, input packet_accepted, input update_enable,
        input firmware_version, input image_total_size, input package_count,
        input payload_length, output ready
    );
endinterface

FILE: hdl/length_prefixed_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Parses start byte, 32-bit length prefix, payload and end byte; one result
// per frame reporting the end marker and the update information packet.
// ----------------------------------------------------------------------------
//  Channel   Dir  Item                 Handshake
//  i_byte    in   one stream byte      valid & ready
//  o_res     out  one frame result     valid & ready
//  i_cfg_*   in   register write       i_cfg_we
//
//  One byte per cycle sustained unless a held result stalls the input; a
//  result is registered once its end byte leaves the input register.
//  Synchronous active-low reset: idle phase, counters clear, max length 512,
//  command code 0x0122.
//  A held result stalls the input only when the held byte is in the
//  end-byte phase; all other bytes keep flowing.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser #(
    parameter int unsigned HEADER_STORE_BYTES = 13
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lpfp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lpfp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    lpfp_byte_if.sink                          i_byte,
    lpfp_result_if.source                      o_res
);
    import lpfp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic [15:0] r_max_len;
    logic [15:0] r_cmd_code;

    logic        r_out_valid;
    logic        r_eot_missing;
    logic        r_accepted;
    logic        r_update_enable;
    logic [15:0] r_fw_version;
    logic [31:0] r_image_size;
    logic [31:0] r_pkg_count;
    logic [31:0] r_payload_len;

    t_ctrl_stat  w_stat;
    t_hdr_fields w_hdr;
    logic        w_step;
    logic        w_emit;
    logic        w_accept;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= MAX_PAYLOAD_LEN_RESET;
            r_cmd_code <= COMMAND_CODE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_PAYLOAD_LEN: r_max_len  <= i_cfg_data;
                CFG_COMMAND_CODE:    r_cmd_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Advance the held byte unless it produces a result with no room for it
    assign w_step = r_in_valid && (!w_stat.eot_byte || !r_out_valid || o_res.ready);
    assign w_emit = w_step && w_stat.eot_byte;
    assign i_byte.ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready && i_byte.valid) begin
            r_in_byte <= i_byte.byte_in;
        end
    end

    lpfp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_stat  (w_stat)
    );

    lpfp_hdr_store #(
        .HEADER_STORE_BYTES (HEADER_STORE_BYTES)
    ) u_hdr_store (
        .i_clk    (i_clk),
        .i_we     (w_step && w_stat.data_byte),
        .i_count  (w_stat.count),
        .i_byte   (r_in_byte),
        .o_fields (w_hdr)
    );

    // Packet check: length window and command code
    assign w_accept = (w_stat.count >= INFO_PACKET_LEN)
                   && (w_stat.count <= {16'd0, r_max_len})
                   && (w_hdr.command == r_cmd_code);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_eot_missing   <= (r_in_byte != END_BYTE);
            r_accepted      <= w_accept;
            r_update_enable <= w_accept && w_hdr.update_enable;
            r_fw_version    <= w_accept ? w_hdr.firmware_version : 16'd0;
            r_image_size    <= w_accept ? w_hdr.image_total_size : 32'd0;
            r_pkg_count     <= w_accept ? w_hdr.package_count : 32'd0;
            r_payload_len   <= w_stat.count;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.eot_missing      = r_eot_missing;
    assign o_res.packet_accepted  = r_accepted;
    assign o_res.update_enable    = r_update_enable;
    assign o_res.firmware_version = r_fw_version;
    assign o_res.image_total_size = r_image_size;
    assign o_res.package_count    = r_pkg_count;
    assign o_res.payload_length   = r_payload_len;

`ifndef NO_ASSERTIONS
    // A held byte that cannot advance stays in the input register
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_step) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost");

    // A result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |-> !w_emit)
        else $error("pending result overwritten");

    // An accepted packet always carries at least the information header
    a_accept_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_accepted) |-> (r_payload_len >= INFO_PACKET_LEN))
        else $error("accepted packet shorter than header");
`endif

endmodule

FILE: hdl/lpfp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_ctrl
// Frame phase sequencer: start byte, length prefix, payload count, end byte.
// ----------------------------------------------------------------------------
module lpfp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output lpfp_pkg::t_ctrl_stat o_stat
);
    import lpfp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_exp_len, n_exp_len;
    logic [2:0]  r_len_left, n_len_left;
    logic [31:0] r_count, n_count;
    logic [31:0] w_count_inc;
    logic [2:0]  w_len_dec;

    // Saturating payload count and prefix countdown
    assign w_count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 32'd1;
    assign w_len_dec   = r_len_left - 3'd1;

    // Next phase
    always_comb begin
        n_phase = r_phase;
        if (i_step) begin
            case (r_phase)
                PH_WAIT_START: begin
                    if (i_byte == START_BYTE) n_phase = PH_WAIT_LEN;
                end
                PH_WAIT_LEN: begin
                    if (w_len_dec == 3'd0) n_phase = PH_WAIT_DATA;
                end
                PH_WAIT_DATA: begin
                    if (w_count_inc >= r_exp_len) n_phase = PH_WAIT_EOT;
                end
                PH_WAIT_EOT: begin
                    n_phase = PH_WAIT_START;
                end
                default: begin
                    n_phase = PH_WAIT_START;
                end
            endcase
        end
    end

    // Length and count registers
    always_comb begin
        n_exp_len  = r_exp_len;
        n_len_left = r_len_left;
        n_count    = r_count;
        if (i_step) begin
            case (r_phase)
                PH_WAIT_START: begin
                    if (i_byte == START_BYTE) begin
                        n_exp_len  = 32'd0;
                        n_len_left = LEN_PREFIX_BYTES;
                        n_count    = 32'd0;
                    end
                end
                PH_WAIT_LEN: begin
                    n_exp_len  = {r_exp_len[23:0], i_byte};
                    n_len_left = w_len_dec;
                end
                PH_WAIT_DATA: begin
                    n_count = w_count_inc;
                end
                default: begin
                end
            endcase
        end
    end

    // Status outputs
    always_comb begin
        o_stat.data_byte = (r_phase == PH_WAIT_DATA);
        o_stat.eot_byte  = (r_phase == PH_WAIT_EOT);
        o_stat.count     = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_WAIT_START;
            r_exp_len  <= 32'd0;
            r_len_left <= 3'd0;
            r_count    <= 32'd0;
        end else begin
            r_phase    <= n_phase;
            r_exp_len  <= n_exp_len;
            r_len_left <= n_len_left;
            r_count    <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    // The prefix countdown runs only while the length is gathered
    a_len_left_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT_LEN) |-> (r_len_left != 3'd0))
        else $error("length countdown empty in length phase");

    // A start byte in the idle phase opens a frame with a clear count
    a_start_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PH_WAIT_START && i_byte == START_BYTE)
        |=> (r_phase == PH_WAIT_LEN && r_count == 32'd0))
        else $error("start byte did not open a frame");

    // The end-byte phase is only reached with at least one payload byte
    a_eot_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_WAIT_EOT) |-> (r_count != 32'd0))
        else $error("end phase with empty payload");
`endif

endmodule

FILE: hdl/lpfp_hdr_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpfp_hdr_store
// Holds the leading payload bytes and decodes the information packet fields.
// ----------------------------------------------------------------------------
module lpfp_hdr_store #(
    parameter int unsigned HEADER_STORE_BYTES = 13
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [31:0]          i_count,
    input  logic [7:0]           i_byte,
    output lpfp_pkg::t_hdr_fields o_fields
);
    import lpfp_pkg::*;

    localparam int unsigned IDX_W = $clog2(HEADER_STORE_BYTES);

    logic [7:0] r_store [HEADER_STORE_BYTES];

    // Keep payload bytes while the count is inside the store
    always_ff @(posedge i_clk) begin
        if (i_we && (i_count < 32'(HEADER_STORE_BYTES))) begin
            r_store[i_count[IDX_W-1:0]] <= i_byte;
        end
    end

    // Big-endian field decode
    always_comb begin
        o_fields.command          = {r_store[0], r_store[1]};
        o_fields.update_enable    = (r_store[2] != 8'd0);
        o_fields.firmware_version = {r_store[3], r_store[4]};
        o_fields.image_total_size = {r_store[5], r_store[6], r_store[7], r_store[8]};
        o_fields.package_count    = {r_store[9], r_store[10], r_store[11], r_store[12]};
    end

endmodule
